// ----- design/mcr_pkg.sv -----
package mcr_pkg;

   localparam logic FUNC_START = 1'b0;
   localparam logic FUNC_STEP  = 1'b1;

   localparam int DEC_START    = 3;
   localparam int DEC_INC_EAST = 6;
   localparam int DEC_INC_DIAG = 10;

   localparam int POINTS      = 16;
   localparam int POINT_IDX_W = $clog2(POINTS);

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic invalid;
      logic done;
   } ctl_type;

endpackage

// ----- design/mcr_front.sv -----
module mcr_front #(
   parameter int COORD_BITS = 10
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic                               req_tuser,
   input  logic [8*((3*COORD_BITS+7)/8)-1:0]  req_tdata,
   input  logic                               q_full,
   output logic                               q_push,
   output mcr_pkg::ctl_type                   q_ctl,
   output logic [2*COORD_BITS+4*(COORD_BITS+1)-1:0] q_data
);

   localparam int AW = COORD_BITS + 1;
   localparam int DW = COORD_BITS + 6;

   logic [COORD_BITS-1:0] cx_ff, cx_in;
   logic [COORD_BITS-1:0] cy_ff, cy_in;
   logic [AW-1:0]         x_ff, x_in;
   logic [AW-1:0]         y_ff, y_in;
   logic signed [DW-1:0]  d_ff, d_in;
   logic                  active_ff, active_in;

   logic                  accept;
   logic                  is_step;
   logic                  can_step;
   logic [AW-1:0]         x1;
   logic [AW-1:0]         y1;
   logic signed [DW-1:0]  d1;
   logic signed [DW-1:0]  x1w;
   logic                  done;
   logic [COORD_BITS-1:0] radius;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && !q_full;
   assign is_step    = (req_tuser == mcr_pkg::FUNC_STEP);
   assign can_step   = active_ff && (x_ff < y_ff);
   assign radius     = req_tdata[3*COORD_BITS-1:2*COORD_BITS];

   always_comb begin
      x1  = x_ff + AW'(1);
      x1w = DW'(x1);
      if (d_ff[DW-1]) begin
         y1 = y_ff;
         d1 = d_ff + (x1w <<< 2) + DW'(mcr_pkg::DEC_INC_EAST);
      end else begin
         y1 = y_ff - AW'(1);
         d1 = d_ff + ((x1w - DW'(y1)) <<< 2) + DW'(mcr_pkg::DEC_INC_DIAG);
      end
      done = (x1 >= y1);
   end

   assign q_push       = accept && is_step;
   assign q_ctl.invalid = !can_step;
   assign q_ctl.done    = !can_step || done;
   assign q_data        = {cx_ff, cy_ff, x_ff, y_ff, x1, y1};

   always_comb begin
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      d_in      = d_ff;
      active_in = active_ff;
      if (accept) begin
         if (!is_step) begin
            cx_in     = req_tdata[COORD_BITS-1:0];
            cy_in     = req_tdata[2*COORD_BITS-1:COORD_BITS];
            x_in      = '0;
            y_in      = AW'(radius);
            d_in      = DW'(mcr_pkg::DEC_START) - (DW'(radius) <<< 1);
            active_in = 1'b1;
         end else if (can_step) begin
            x_in      = x1;
            y_in      = y1;
            d_in      = d1;
            active_in = !done;
         end else begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
      cx_ff <= cx_in;
      cy_ff <= cy_in;
      x_ff  <= x_in;
      y_ff  <= y_in;
      d_ff  <= d_in;
   end

endmodule

// ----- design/mcr_queue.sv -----
module mcr_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = mcr_pkg::QUEUE_PTR_W;
   localparam int CW = PW + 1;

   logic [WIDTH-1:0] mem_ff [mcr_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign full     = (count_ff == CW'(mcr_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- design/mcr_back.sv -----
module mcr_back #(
   parameter int COORD_BITS = 10
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     q_empty,
   input  mcr_pkg::ctl_type                         q_ctl,
   input  logic [2*COORD_BITS+4*(COORD_BITS+1)-1:0] q_data,
   output logic                                     q_pop,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [8*((2*(COORD_BITS+2)+7)/8)-1:0]    rsp_tdata,
   output logic [1:0]                               rsp_tuser,
   output logic                                     rsp_tlast
);

   localparam int AW  = COORD_BITS + 1;
   localparam int OW  = COORD_BITS + 2;
   localparam int ODW = 8 * ((2 * OW + 7) / 8);
   localparam int IW  = mcr_pkg::POINT_IDX_W;

   logic                  busy_ff, busy_in;
   logic [IW-1:0]         idx_ff, idx_in;
   mcr_pkg::ctl_type      ctl_ff;
   logic [COORD_BITS-1:0] cx_ff, cy_ff;
   logic [AW-1:0]         x0_ff, y0_ff, x1_ff, y1_ff;

   logic                  out_valid_ff, out_valid_in;
   logic signed [OW-1:0]  px_ff, py_ff;
   logic                  pvalid_ff, last_ff, done_ff;

   logic                  adv;
   logic                  fin;
   logic                  load;
   logic [AW-1:0]         a, b, dx, dy;
   logic signed [OW-1:0]  dxw, dyw;
   logic signed [OW-1:0]  px, py;

   always_comb begin
      a  = idx_ff[3] ? x1_ff : x0_ff;
      b  = idx_ff[3] ? y1_ff : y0_ff;
      dx = idx_ff[2] ? b : a;
      dy = idx_ff[2] ? a : b;
      dxw = OW'(dx);
      dyw = OW'(dy);
      px = OW'(cx_ff) + (idx_ff[0] ? -dxw : dxw);
      py = OW'(cy_ff) + (idx_ff[1] ? -dyw : dyw);
   end

   assign adv   = busy_ff && (!out_valid_ff || rsp_tready);
   assign fin   = adv && (ctl_ff.invalid || (idx_ff == IW'(mcr_pkg::POINTS - 1)));
   assign load  = (!busy_ff || fin) && !q_empty;
   assign q_pop = load;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (load) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (fin) begin
         busy_in = 1'b0;
      end else if (adv) begin
         idx_in = idx_ff + IW'(1);
      end
      if (adv) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
      if (load) begin
         ctl_ff <= q_ctl;
         {cx_ff, cy_ff, x0_ff, y0_ff, x1_ff, y1_ff} <= q_data;
      end
      if (adv) begin
         if (ctl_ff.invalid) begin
            px_ff     <= '0;
            py_ff     <= '0;
            pvalid_ff <= 1'b0;
         end else begin
            px_ff     <= px;
            py_ff     <= py;
            pvalid_ff <= 1'b1;
         end
         last_ff <= fin;
         done_ff <= ctl_ff.done;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = ODW'({py_ff, px_ff});
   assign rsp_tuser  = {done_ff, pvalid_ff};
   assign rsp_tlast  = last_ff;

endmodule

// ----- design/midpoint_circle_raster.sv -----
// A start transaction yields no results.
// A step transaction is pushed into the queue, loaded into the back end and registered at the
// output: sixteen results per step, one result per cycle while rsp_tready holds high.
// A step with no active circle yields a single result.
// Synchronous reset clears the control state; no circle is active after reset.
module midpoint_circle_raster #(
   parameter int COORD_BITS = 10
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic                                  req_tuser,   // func
   input  logic [8*((3*COORD_BITS+7)/8)-1:0]     req_tdata,   // center_x, center_y, radius
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [8*((2*(COORD_BITS+2)+7)/8)-1:0] rsp_tdata,   // pixel_x, pixel_y
   output logic [1:0]                            rsp_tuser,   // pixel_valid, circle_done
   output logic                                  rsp_tlast
);

   localparam int PW = 2 * COORD_BITS + 4 * (COORD_BITS + 1);
   localparam int CW = $bits(mcr_pkg::ctl_type);

   logic             q_full;
   logic             q_push;
   logic             q_pop;
   logic             q_empty;
   mcr_pkg::ctl_type push_ctl;
   mcr_pkg::ctl_type pop_ctl;
   logic [PW-1:0]    push_data;
   logic [PW-1:0]    pop_data;

   mcr_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_ctl      (push_ctl),
      .q_data     (push_data)
   );

   mcr_queue #(.WIDTH(CW + PW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_ctl, push_data}),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  ({pop_ctl, pop_data})
   );

   mcr_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_ctl      (pop_ctl),
      .q_data     (pop_data),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
